@@ hdl/lfid_pkg.sv @@
// Package for the lowest-free identifier allocator.
// Sizes, request and response words, status codes and sequencer states.
// No dependencies.
package lfid_pkg;

  // Sizing; WORD_BITS must be a power of two
  localparam int ID_CAPACITY = 4096;
  localparam int WORD_BITS   = 64;
  localparam int NWORDS      = (ID_CAPACITY + WORD_BITS - 1) / WORD_BITS;

  localparam int ID_W      = 13;
  localparam int STATUS_W  = 2;
  localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CAP_W     = $clog2(ID_CAPACITY + 1);
  localparam int CMP_W     = ((ID_W > CAP_W) ? ID_W : CAP_W) + 1;
  localparam int ENC_W     = (NWORDS > WORD_BITS) ? NWORDS : WORD_BITS;
  localparam int ENC_IDX_W = (ENC_W > 1) ? $clog2(ENC_W) : 1;

  localparam logic [STATUS_W-1:0] STAT_ALLOC   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FREED   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] id_value;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Control from the sequencer to the bitmap store
  typedef struct packed {
    logic              rd_en;
    logic [WIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_addr;
  } map_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_WRITE
  } seq_state_t;

endpackage

@@ hdl/lowest_free_id_allocator.sv @@
// Lowest-free identifier allocator, top level.
// Holds the sequencer and the limit register; uses lfid_map, lfid_lzenc, lfid_pkg.
//
// Requests: a word (kind, id_value) is taken at a clock edge with start high
// and busy low. kind allocate hands out the lowest free identifier in
// 1..id_limit; kind free returns id_value to the pool.
// Results: each request gives exactly one response word (granted_id, status)
// on rsp, marked by done for one cycle. The receiver cannot stall; rsp holds
// until the next request has been searched.
// Sequence: after the accepting edge the state runs S_FIND, then S_WRITE, with
// busy high in both; done is registered from S_WRITE, and start is taken again
// in the cycle that carries done, so a new request waits until the last is done.
// The sequence comes from the one lowest-zero finder, used first on the
// full-word summary and then on the word read from the bitmap, and from the
// registered read of the bitmap memory in between.
// Configuration: cfg_we with cfg_wdata writes id_limit; values above the capacity
// act as the capacity. Writing only with no request in flight is up to the user.
// Reset: synchronous on rst; every identifier is free at once (per-word valid
// bits, no clearing pass), id_limit returns to 4096.
module lowest_free_id_allocator (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  lfid_pkg::req_t           req,
  input  logic                     cfg_we,
  input  logic [lfid_pkg::ID_W-1:0] cfg_wdata,
  output logic                     done,
  output lfid_pkg::rsp_t           rsp
);
  import lfid_pkg::*;

  seq_state_t state, state_next;

  logic [ID_W-1:0]      id_limit;
  logic                 req_kind;
  logic                 skip;
  logic [WIDX_W-1:0]    word_addr;
  logic [BIT_W-1:0]     bit_idx;
  logic [WORD_BITS-1:0] new_word;
  logic                 wr_pending;

  map_ctl_t             ctl;
  logic [WORD_BITS-1:0] rd_word;
  logic [NWORDS-1:0]    summary;

  logic [ENC_W-1:0]     enc_in;
  logic                 enc_found;
  logic [ENC_IDX_W-1:0] enc_idx;
  logic [ENC_W-1:0]     enc_onehot;

  logic                 accept;
  logic [CMP_W-1:0]     lim_ext;
  logic [CMP_W-1:0]     eff_lim;
  logic [CMP_W-1:0]     idv_ext;
  logic [CMP_W-1:0]     free_k;
  logic                 free_ok;
  logic                 skip_next;
  logic [WIDX_W-1:0]    addr_next;
  logic [CMP_W-1:0]     cand_id;
  logic                 alloc_ok;
  logic                 free_hit;

  lfid_map u_map (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .wr_word (new_word),
    .rd_word (rd_word),
    .summary (summary)
  );

  lfid_lzenc u_enc (
    .vec    (enc_in),
    .found  (enc_found),
    .idx    (enc_idx),
    .onehot (enc_onehot)
  );

  // Shared finder: summary while idle, the fetched word afterwards
  always_comb begin
    enc_in = '1;
    if (state == S_IDLE) begin
      enc_in[NWORDS-1:0] = summary;
    end else begin
      enc_in[WORD_BITS-1:0] = rd_word;
    end
  end

  always_comb begin
    lim_ext = CMP_W'(id_limit);
    eff_lim = (lim_ext > CMP_W'(ID_CAPACITY)) ? CMP_W'(ID_CAPACITY) : lim_ext;
    idv_ext = CMP_W'(req.id_value);
    free_k  = idv_ext - CMP_W'(1);
    free_ok = (idv_ext != '0) && (idv_ext <= eff_lim);
    cand_id = (CMP_W'(word_addr) << BIT_W) + CMP_W'(enc_idx[BIT_W-1:0]) + CMP_W'(1);
    alloc_ok = !skip && enc_found && (cand_id <= eff_lim);
    free_hit = !skip && rd_word[bit_idx];
  end

  always_comb begin
    accept     = start && (state == S_IDLE);
    busy       = (state != S_IDLE);
    state_next = state;
    skip_next  = 1'b0;
    addr_next  = WIDX_W'(free_k >> BIT_W);
    if (req.kind == KIND_ALLOC) begin
      addr_next = enc_idx[WIDX_W-1:0];
      skip_next = !enc_found;
    end else begin
      skip_next = !free_ok;
    end
    ctl.rd_en   = accept;
    ctl.rd_addr = addr_next;
    ctl.wr_en   = (state == S_WRITE) && wr_pending;
    ctl.wr_addr = word_addr;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FIND;
        end
      end
      S_FIND:  state_next = S_WRITE;
      S_WRITE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      id_limit <= ID_W'(4096);
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_WRITE);
      if (cfg_we) begin
        id_limit <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= req.kind;
      skip      <= skip_next;
      word_addr <= addr_next;
      bit_idx   <= free_k[BIT_W-1:0];
    end
    if (state == S_FIND) begin
      if (req_kind == KIND_ALLOC) begin
        wr_pending     <= alloc_ok;
        new_word       <= rd_word | enc_onehot[WORD_BITS-1:0];
        rsp.granted_id <= alloc_ok ? cand_id[ID_W-1:0] : '0;
        rsp.status     <= alloc_ok ? STAT_ALLOC : STAT_EMPTY;
      end else begin
        wr_pending     <= free_hit;
        new_word       <= rd_word & ~(WORD_BITS'(1) << bit_idx);
        rsp.granted_id <= '0;
        rsp.status     <= free_hit ? STAT_FREED : STAT_IGNORED;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("response shown while a request is in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted request did not raise busy");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |=> done) else $error("write step gave no response");

  a_grant_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == STAT_ALLOC) |-> (rsp.granted_id != '0))
    else $error("allocation granted identifier zero");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_ALLOC) |-> (rsp.granted_id == '0))
    else $error("non-allocation response carries an identifier");

endmodule

@@ hdl/lfid_lzenc.sv @@
// Lowest-zero finder shared by the summary search and the word search.
// Combinational; depends on lfid_pkg.
module lfid_lzenc (
  input  logic [lfid_pkg::ENC_W-1:0]     vec,
  output logic                           found,
  output logic [lfid_pkg::ENC_IDX_W-1:0] idx,
  output logic [lfid_pkg::ENC_W-1:0]     onehot
);
  import lfid_pkg::*;

  logic [ENC_W-1:0] inv;

  always_comb begin
    inv    = ~vec;
    // isolate the lowest set bit of the inverted word
    onehot = inv & (~inv + ENC_W'(1));
    found  = |inv;
    idx    = '0;
    for (int i = 0; i < ENC_W; i++) begin
      if (onehot[i]) begin
        idx = idx | ENC_IDX_W'(i);
      end
    end
  end

endmodule

@@ hdl/lfid_map.sv @@
// Used bitmap store: word memory with registered read, per-word valid bits
// and the full-word summary. Depends on lfid_pkg.
module lfid_map (
  input  logic                            clk,
  input  logic                            rst,
  input  lfid_pkg::map_ctl_t              ctl,
  input  logic [lfid_pkg::WORD_BITS-1:0]  wr_word,
  output logic [lfid_pkg::WORD_BITS-1:0]  rd_word,
  output logic [lfid_pkg::NWORDS-1:0]     summary
);
  import lfid_pkg::*;

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [NWORDS-1:0]    word_valid;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      summary    <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        word_valid[ctl.wr_addr] <= 1'b1;
        summary[ctl.wr_addr]    <= &wr_word;
      end
      if (ctl.rd_en) begin
        rd_valid <= word_valid[ctl.rd_addr];
      end
    end
  end

  // a word never written reads as all free
  assign rd_word = rd_valid ? rd_data : '0;

endmodule
